### src/motion_strike_qualifier_macros.svh
// Assertion macros shared by the motion strike qualifier RTL.
`ifndef MOTION_STRIKE_QUALIFIER_MACROS_SVH
`define MOTION_STRIKE_QUALIFIER_MACROS_SVH

`ifndef SYNTHESIS

// Property that must hold at every clock edge out of reset.
`define MSQ_ASSERT(label, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("motion_strike_qualifier: assertion failed");

// Antecedent in one cycle implies consequent in the next.
`define MSQ_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("motion_strike_qualifier: assertion failed");

`else

`define MSQ_ASSERT(label, prop)
`define MSQ_ASSERT_NEXT(label, ante, cons)

`endif

`endif

### src/msq_pkg.sv
// Package with widths, reset values and register codes of the motion strike qualifier.
package msq_pkg;

    localparam int TIMER_BITS_DEF = 24;
    localparam int CFG_TIMER_W    = 24;
    localparam int STRIKE_W       = 8;
    localparam int BG_W           = 9;
    localparam int REPORT_W       = 8;
    localparam int ADDR_W         = 5;
    localparam int DATA_W         = 32;

    localparam logic                SENSOR_ENABLED_RST = 1'b1;
    localparam logic [STRIKE_W-1:0] STRIKE_LIMIT_RST   = 8'd3;
    localparam int                  BLIND_TICKS_RST      = 1000;
    localparam int                  EXPOSURE_TICKS_RST   = 10000;
    localparam int                  BACKGROUND_TICKS_RST = 80000;

    localparam logic [STRIKE_W-1:0] STRIKE_MAX = '1;
    localparam logic [BG_W-1:0]     BG_MAX     = '1;

    typedef enum logic [2:0] {
        REG_SENSOR_ENABLED   = 3'd0,
        REG_STRIKE_LIMIT     = 3'd1,
        REG_BLIND_TICKS      = 3'd2,
        REG_EXPOSURE_TICKS   = 3'd3,
        REG_BACKGROUND_TICKS = 3'd4
    } msq_reg_t;

endpackage

### src/msq_if.sv
// Handshake interfaces for the tick input and the report output channels.
interface msq_tick_if;
    import msq_pkg::*;

    logic valid;
    logic ready;
    logic sensor_level;
    logic force_strike;
    logic restart;

    modport source (output valid, output sensor_level, output force_strike,
                    output restart, input ready);
    modport sink (input valid, input sensor_level, input force_strike,
                  input restart, output ready);
endinterface

interface msq_report_if;
    import msq_pkg::*;

    logic                valid;
    logic                ready;
    logic [REPORT_W-1:0] report_value;
    logic                alarm;
    logic [STRIKE_W-1:0] strike_count;
    logic [BG_W-1:0]     background_count;
    logic                strike_taken;
    logic                disabled_hit;

    modport source (output valid, output report_value, output alarm,
                    output strike_count, output background_count,
                    output strike_taken, output disabled_hit, input ready);
    modport sink (input valid, input report_value, input alarm,
                  input strike_count, input background_count,
                  input strike_taken, input disabled_hit, output ready);
endinterface

### src/motion_strike_qualifier.sv
// Motion strike qualifier: one millisecond tick in, one report out.
// The tick channel carries the sensor level, a forced-strike request and a
// restart; each accepted transaction produces exactly one report transaction
// with the report value, alarm, counts after the tick and strike flags.
// A tick passes an input register and then the result register before its
// report is offered. Strike state is updated as the tick moves from the input
// register to the result register, so one tick per cycle is sustained while
// the receiver keeps report ready high.
// When the receiver stalls, the report waits in the result register and one
// further tick may wait in the input register; ready then drops until the
// report is taken. Nothing is lost or repeated.
// The APB-style port writes sensor_enabled, strike_limit, blind_ticks,
// exposure_ticks and background_ticks at byte addresses 0, 4, 8, 12 and 16.
// Writes are expected only while no tick is in flight; pready is always high.
// Reset loads the register defaults, clears all counts and expires all timers.
`include "motion_strike_qualifier_macros.svh"

module motion_strike_qualifier #(
    parameter int TIMER_BITS = msq_pkg::TIMER_BITS_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [msq_pkg::ADDR_W-1:0]  paddr,
    input  logic [msq_pkg::DATA_W-1:0]  pwdata,
    output logic [msq_pkg::DATA_W-1:0]  prdata,
    output logic                        pready,
    msq_tick_if.sink                    tick,
    msq_report_if.source                report
);
    import msq_pkg::*;

    localparam int CFG_BITS = (TIMER_BITS < CFG_TIMER_W) ? TIMER_BITS : CFG_TIMER_W;

    // Configuration registers
    logic                sensor_enabled_reg;
    logic [STRIKE_W-1:0] strike_limit_reg;
    logic [CFG_BITS-1:0] blind_ticks_reg;
    logic [CFG_BITS-1:0] exposure_ticks_reg;
    logic [CFG_BITS-1:0] background_ticks_reg;
    logic                cfg_write;
    msq_reg_t            reg_sel;

    // Input register
    logic in_valid_reg;
    logic in_level_reg;
    logic in_force_reg;
    logic in_restart_reg;

    // Qualifier state
    logic                  previous_level_reg, previous_level_next;
    logic [STRIKE_W-1:0]   strikes_reg, strikes_next;
    logic [BG_W-1:0]       background_reg, background_next;
    logic [TIMER_BITS-1:0] blind_left_reg, blind_left_next;
    logic [TIMER_BITS:0]   exposure_left_reg, exposure_left_next;
    logic [TIMER_BITS-1:0] background_left_reg, background_left_next;

    // Result register
    logic                out_valid_reg;
    logic [REPORT_W-1:0] report_value_reg, report_value_next;
    logic                alarm_reg, alarm_next;
    logic [STRIKE_W-1:0] strike_count_reg;
    logic [BG_W-1:0]     background_count_reg;
    logic                strike_taken_reg, strike_taken_next;
    logic                disabled_hit_reg, disabled_hit_next;

    logic advance;
    logic accept;

    // Intermediate values of the update
    logic                strikes_start, strikes_hit, strikes_drop;
    logic [BG_W-1:0]     bg_start, bg_drop, bg_final;
    logic                blind_exp, expo_exp, back_exp;
    logic                expo_loaded, back_loaded;
    logic                strike_event;

    // ---------------- configuration port ----------------
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;
    assign reg_sel   = msq_reg_t'(paddr[ADDR_W-1:2]);

    always_comb
    begin
        unique case (reg_sel)
            REG_SENSOR_ENABLED:   prdata = DATA_W'(sensor_enabled_reg);
            REG_STRIKE_LIMIT:     prdata = DATA_W'(strike_limit_reg);
            REG_BLIND_TICKS:      prdata = DATA_W'(blind_ticks_reg);
            REG_EXPOSURE_TICKS:   prdata = DATA_W'(exposure_ticks_reg);
            REG_BACKGROUND_TICKS: prdata = DATA_W'(background_ticks_reg);
            default:              prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sensor_enabled_reg   <= SENSOR_ENABLED_RST;
            strike_limit_reg     <= STRIKE_LIMIT_RST;
            blind_ticks_reg      <= CFG_BITS'(BLIND_TICKS_RST);
            exposure_ticks_reg   <= CFG_BITS'(EXPOSURE_TICKS_RST);
            background_ticks_reg <= CFG_BITS'(BACKGROUND_TICKS_RST);
        end
        else if (cfg_write)
        begin
            unique case (reg_sel)
                REG_SENSOR_ENABLED:   sensor_enabled_reg   <= pwdata[0];
                REG_STRIKE_LIMIT:     strike_limit_reg     <= pwdata[STRIKE_W-1:0];
                REG_BLIND_TICKS:      blind_ticks_reg      <= pwdata[CFG_BITS-1:0];
                REG_EXPOSURE_TICKS:   exposure_ticks_reg   <= pwdata[CFG_BITS-1:0];
                REG_BACKGROUND_TICKS: background_ticks_reg <= pwdata[CFG_BITS-1:0];
                default:              ;
            endcase
        end
    end

    // ---------------- handshake ----------------
    assign advance    = in_valid_reg && (!out_valid_reg || report.ready);
    assign tick.ready = !in_valid_reg || advance;
    assign accept     = tick.valid && tick.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
                in_valid_reg <= 1'b1;
            else if (advance)
                in_valid_reg <= 1'b0;

            if (advance)
                out_valid_reg <= 1'b1;
            else if (report.ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            in_level_reg   <= tick.sensor_level;
            in_force_reg   <= tick.force_strike;
            in_restart_reg <= tick.restart;
        end
    end

    // ---------------- tick update ----------------
    logic [STRIKE_W-1:0] strikes_a, strikes_b, strikes_c;

    always_comb
    begin
        strikes_a   = in_restart_reg ? '0 : strikes_reg;
        bg_start    = in_restart_reg ? '0 : background_reg;

        blind_exp   = (blind_left_reg == '0);
        expo_exp    = (exposure_left_reg == '0);
        back_exp    = (background_left_reg == '0);

        blind_left_next      = blind_exp ? '0 : blind_left_reg - 1'b1;
        exposure_left_next   = expo_exp  ? '0 : exposure_left_reg - 1'b1;
        background_left_next = back_exp  ? '0 : background_left_reg - 1'b1;

        previous_level_next = previous_level_reg;
        expo_loaded         = 1'b0;
        back_loaded         = 1'b0;
        strike_taken_next   = 1'b0;
        disabled_hit_next   = 1'b0;
        strikes_b           = strikes_a;
        strike_event        = in_force_reg || (in_level_reg && !previous_level_reg);

        // Edges are looked at only once the blind time is over or a strike is forced.
        if (in_force_reg || blind_exp)
        begin
            previous_level_next = in_level_reg;
            if (strike_event)
            begin
                if (sensor_enabled_reg)
                begin
                    blind_left_next = TIMER_BITS'(blind_ticks_reg);
                    if (strikes_a == '0)
                    begin
                        exposure_left_next = (TIMER_BITS+1)'(blind_ticks_reg)
                                           + (TIMER_BITS+1)'(exposure_ticks_reg);
                        expo_loaded = 1'b1;
                    end
                    if (strikes_a != STRIKE_MAX)
                        strikes_b = strikes_a + 1'b1;
                    strike_taken_next = 1'b1;
                end
                else
                begin
                    disabled_hit_next = 1'b1;
                end
            end
        end

        // An expired exposure window turns pending strikes into background.
        strikes_c = strikes_b;
        bg_drop   = bg_start;
        if (expo_exp && !expo_loaded && (strikes_b != '0))
        begin
            if (bg_start == '0)
            begin
                background_left_next = TIMER_BITS'(background_ticks_reg);
                back_loaded = 1'b1;
            end
            if (bg_start != BG_MAX)
                bg_drop = bg_start + 1'b1;
            strikes_c = '0;
        end

        bg_final = (back_exp && !back_loaded) ? '0 : bg_drop;

        report_value_next = strikes_c;
        alarm_next        = 1'b0;
        strikes_next      = strikes_c;
        background_next   = bg_final;
        if (strikes_c >= strike_limit_reg)
        begin
            alarm_next      = 1'b1;
            strikes_next    = '0;
            background_next = '0;
        end
        if (bg_final > BG_W'(strike_limit_reg))
        begin
            alarm_next        = 1'b1;
            report_value_next = REPORT_W'(1);
            strikes_next      = '0;
            background_next   = '0;
        end
    end

    // These signals name steps of the update for readability and for the assertions.
    assign strikes_start = (strikes_a == '0);
    assign strikes_hit   = (strikes_b != strikes_a);
    assign strikes_drop  = (strikes_c != strikes_b);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            previous_level_reg  <= 1'b0;
            strikes_reg         <= '0;
            background_reg      <= '0;
            blind_left_reg      <= '0;
            exposure_left_reg   <= '0;
            background_left_reg <= '0;
        end
        else if (advance)
        begin
            previous_level_reg  <= previous_level_next;
            strikes_reg         <= strikes_next;
            background_reg      <= background_next;
            blind_left_reg      <= blind_left_next;
            exposure_left_reg   <= exposure_left_next;
            background_left_reg <= background_left_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            report_value_reg     <= report_value_next;
            alarm_reg            <= alarm_next;
            strike_count_reg     <= strikes_next;
            background_count_reg <= background_next;
            strike_taken_reg     <= strike_taken_next;
            disabled_hit_reg     <= disabled_hit_next;
        end
    end

    assign report.valid            = out_valid_reg;
    assign report.report_value     = report_value_reg;
    assign report.alarm            = alarm_reg;
    assign report.strike_count     = strike_count_reg;
    assign report.background_count = background_count_reg;
    assign report.strike_taken     = strike_taken_reg;
    assign report.disabled_hit     = disabled_hit_reg;

    // ---------------- assertions ----------------
    `MSQ_ASSERT(a_alarm_clears, !(out_valid_reg && alarm_reg) || ((strike_count_reg == '0) && (background_count_reg == '0)))
    `MSQ_ASSERT(a_taken_or_disabled, !(out_valid_reg && strike_taken_reg && disabled_hit_reg))
    `MSQ_ASSERT_NEXT(a_advance_fills_result, advance, out_valid_reg)
    `MSQ_ASSERT(a_hit_flags_consistent, !advance || !(strikes_hit && !strike_taken_next) || !strikes_start || strikes_drop || strike_taken_next)

endmodule

### sim/tb.sv
// Self-checking testbench for the motion strike qualifier with a tick-level scoreboard.
`timescale 1ns / 100ps

module tb;
    import msq_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int PHASE_TICKS    = 175;
    localparam int PHASES         = 6;
    localparam logic [23:0] TIMER_MAX = 24'hFFFFFF;

    typedef struct packed {
        logic [REPORT_W-1:0] report_value;
        logic                alarm;
        logic [STRIKE_W-1:0] strike_count;
        logic [BG_W-1:0]     background_count;
        logic                strike_taken;
        logic                disabled_hit;
    } report_t;

    class strike_scoreboard;
        bit                  sensor_en;
        bit [STRIKE_W-1:0]   limit;
        bit [23:0]           blind_cfg;
        bit [23:0]           expo_cfg;
        bit [23:0]           bg_cfg;
        bit                  prev_level;
        bit [STRIKE_W-1:0]   strikes;
        bit [BG_W-1:0]       background;
        bit [23:0]           blind_left;
        bit [24:0]           expo_left;
        bit [23:0]           bg_left;
        report_t             expected_reports[$];
        int                  errors;

        function new();
            sensor_en  = 1'b1;
            limit      = 8'd3;
            blind_cfg  = 24'd1000;
            expo_cfg   = 24'd10000;
            bg_cfg     = 24'd80000;
            prev_level = 1'b0;
            strikes    = '0;
            background = '0;
            blind_left = '0;
            expo_left  = '0;
            bg_left    = '0;
            errors     = 0;
        endfunction

        function void set_register(msq_reg_t idx, logic [31:0] value);
            case (idx)
                REG_SENSOR_ENABLED:   sensor_en = value[0];
                REG_STRIKE_LIMIT:     limit     = value[7:0];
                REG_BLIND_TICKS:      blind_cfg = value[23:0];
                REG_EXPOSURE_TICKS:   expo_cfg  = value[23:0];
                REG_BACKGROUND_TICKS: bg_cfg    = value[23:0];
                default: ;
            endcase
        endfunction

        // Works out the report of one accepted tick and queues it.
        function void predict_tick(bit level, bit force_hit, bit restart);
            bit      blind_exp;
            bit      expo_exp;
            bit      bg_exp;
            bit      expo_loaded;
            bit      bg_loaded;
            report_t r;
            expo_loaded = 1'b0;
            bg_loaded   = 1'b0;
            r           = '0;
            if (restart)
            begin
                strikes    = '0;
                background = '0;
            end
            blind_exp = (blind_left == 0);
            if (!blind_exp)
                blind_left--;
            expo_exp = (expo_left == 0);
            if (!expo_exp)
                expo_left--;
            bg_exp = (bg_left == 0);
            if (!bg_exp)
                bg_left--;

            if (force_hit || blind_exp)
            begin
                if (force_hit || (level && !prev_level))
                begin
                    if (sensor_en)
                    begin
                        blind_left = blind_cfg;
                        if (strikes == 0)
                        begin
                            expo_left   = {1'b0, expo_cfg} + {1'b0, blind_cfg};
                            expo_loaded = 1'b1;
                        end
                        if (strikes != STRIKE_MAX)
                            strikes++;
                        r.strike_taken = 1'b1;
                    end
                    else
                        r.disabled_hit = 1'b1;
                end
                prev_level = level;
            end

            // An expired exposure window turns pending strikes into one background count.
            if (expo_exp && !expo_loaded && strikes != 0)
            begin
                if (background == 0)
                begin
                    bg_left   = bg_cfg;
                    bg_loaded = 1'b1;
                end
                if (background != BG_MAX)
                    background++;
                strikes = '0;
            end
            if (bg_exp && !bg_loaded)
                background = '0;

            r.report_value = strikes;
            if (strikes >= limit)
            begin
                r.alarm    = 1'b1;
                strikes    = '0;
                background = '0;
            end
            if (background > limit)
            begin
                r.alarm        = 1'b1;
                r.report_value = 8'd1;
                strikes        = '0;
                background     = '0;
            end
            r.strike_count     = strikes;
            r.background_count = background;
            expected_reports.push_back(r);
        endfunction

        function void check_report(report_t got);
            report_t want;
            if (expected_reports.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("ERROR: report transaction with no tick pending");
                return;
            end
            want = expected_reports.pop_front();
            if (got !== want)
            begin
                errors++;
                if (errors <= 10)
                begin
                    $display("ERROR: report mismatch: expected value=%0d alarm=%0b strikes=%0d",
                             want.report_value, want.alarm, want.strike_count);
                    $display("       background=%0d taken=%0b disabled=%0b",
                             want.background_count, want.strike_taken, want.disabled_hit);
                    $display("       got value=%0d alarm=%0b strikes=%0d",
                             got.report_value, got.alarm, got.strike_count);
                    $display("       background=%0d taken=%0b disabled=%0b",
                             got.background_count, got.strike_taken, got.disabled_hit);
                end
            end
        endfunction

        function int pending();
            return expected_reports.size();
        endfunction
    endclass

    logic                clk;
    logic                rst_n;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [ADDR_W-1:0]   paddr;
    logic [DATA_W-1:0]   pwdata;
    logic [DATA_W-1:0]   prdata;
    logic                pready;

    msq_tick_if   tick_ch ();
    msq_report_if report_ch ();

    strike_scoreboard sb;
    int send_idle_pct;
    int recv_idle_pct;
    int stall_request;
    int idle_cycles = 0;

    motion_strike_qualifier DUT (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .tick    (tick_ch.sink),
        .report  (report_ch.source)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    task automatic apb_write(msq_reg_t idx, logic [31:0] value);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        sb.set_register(idx, value);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic send_tick(bit level, bit force_hit, bit restart);
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            tick_ch.valid <= 1'b0;
            @(negedge clk);
        end
        tick_ch.valid        <= 1'b1;
        tick_ch.sensor_level <= level;
        tick_ch.force_strike <= force_hit;
        tick_ch.restart      <= restart;
        do
            @(posedge clk);
        while (!tick_ch.ready);
        sb.predict_tick(level, force_hit, restart);
    endtask

    // Lowers valid and waits until every queued report has been taken.
    task automatic drain();
        @(negedge clk);
        tick_ch.valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    task automatic write_settings(bit en, logic [7:0] lim, logic [23:0] blind,
                                  logic [23:0] expo, logic [23:0] bg);
        apb_write(REG_SENSOR_ENABLED, {31'd0, en});
        apb_write(REG_STRIKE_LIMIT, {24'd0, lim});
        apb_write(REG_BLIND_TICKS, {8'd0, blind});
        apb_write(REG_EXPOSURE_TICKS, {8'd0, expo});
        apb_write(REG_BACKGROUND_TICKS, {8'd0, bg});
    endtask

    task automatic random_settings();
        logic [23:0] blind;
        logic [23:0] expo;
        logic [23:0] bg;
        logic [7:0]  lim;
        case ($urandom_range(9))
            0:       blind = 24'd0;
            9:       blind = 24'($urandom_range(20, 60));
            default: blind = 24'($urandom_range(1, 8));
        endcase
        case ($urandom_range(9))
            0:       expo = 24'd0;
            default: expo = 24'($urandom_range(1, 25));
        endcase
        case ($urandom_range(9))
            0:       bg = 24'd0;
            default: bg = 24'($urandom_range(1, 80));
        endcase
        lim = ($urandom_range(9) == 0) ? 8'($urandom_range(7, 255)) : 8'($urandom_range(1, 6));
        write_settings($urandom_range(99) < 85, lim, blind, expo, bg);
    endtask

    // Mostly clean level runs so that edges line up with blind and exposure windows.
    task automatic random_ticks(int n, bit pressure);
        int run_left;
        bit level;
        run_left = 0;
        level    = 1'b0;
        for (int i = 0; i < n; i++)
        begin
            if (pressure && i == n / 3)
                stall_request = 60;
            if ($urandom_range(99) < 10)
                send_tick(1'($urandom_range(1)), 1'($urandom_range(1)),
                          1'($urandom_range(1)));
            else
            begin
                if (run_left == 0)
                begin
                    level    = !level;
                    run_left = ($urandom_range(3) == 0) ? $urandom_range(1, 30)
                                                        : $urandom_range(1, 6);
                end
                run_left--;
                send_tick(level, $urandom_range(99) < 4, $urandom_range(99) < 2);
            end
        end
    endtask

    // Receiver side: random ready, with a long hold-off when one is requested.
    initial
    begin : receiver
        int hold_left;
        hold_left       = 0;
        report_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (stall_request > 0)
            begin
                hold_left     = stall_request;
                stall_request = 0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                report_ch.ready <= 1'b0;
            end
            else
                report_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (report_ch.valid && report_ch.ready)
                sb.check_report({report_ch.report_value, report_ch.alarm,
                                 report_ch.strike_count, report_ch.background_count,
                                 report_ch.strike_taken, report_ch.disabled_hit});
            if ((report_ch.valid && report_ch.ready) || (tick_ch.valid && tick_ch.ready))
                idle_cycles <= 0;
            else if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("Some tests failed");
                $finish;
            end
            else
                idle_cycles <= idle_cycles + 1;
        end
    end

    initial
    begin
        sb                   = new();
        send_idle_pct        = 31;
        recv_idle_pct        = 75;
        stall_request        = 0;
        rst_n                = 1'b0;
        psel                 = 1'b0;
        penable              = 1'b0;
        pwrite               = 1'b0;
        paddr                = '0;
        pwdata               = '0;
        tick_ch.valid        = 1'b0;
        tick_ch.sensor_level = 1'b0;
        tick_ch.force_strike = 1'b0;
        tick_ch.restart      = 1'b0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Edges, blind time, forced strikes and restarts with short timers.
        write_settings(1'b1, 8'd3, 24'd2, 24'd4, 24'd15);
        send_tick(0, 0, 0);
        send_tick(1, 0, 0);
        send_tick(0, 0, 0);
        send_tick(1, 0, 0);
        send_tick(1, 0, 0);
        send_tick(0, 1, 0);
        send_tick(0, 0, 0);
        send_tick(0, 0, 0);
        send_tick(0, 0, 0);
        send_tick(1, 1, 1);
        send_tick(0, 0, 1);
        drain();

        // Strike events while the sensor is disabled.
        apb_write(REG_SENSOR_ENABLED, 32'd0);
        send_tick(1, 0, 0);
        send_tick(0, 1, 0);
        drain();

        // A zero limit fires the alarm on every tick.
        apb_write(REG_SENSOR_ENABLED, 32'd1);
        apb_write(REG_STRIKE_LIMIT, 32'd0);
        send_tick(0, 0, 0);
        send_tick(1, 1, 0);
        drain();

        // Pending strikes above a freshly lowered limit.
        write_settings(1'b1, 8'd10, 24'd0, TIMER_MAX, TIMER_MAX);
        send_tick(0, 1, 0);
        send_tick(1, 0, 0);
        send_tick(0, 1, 0);
        send_tick(1, 1, 0);
        drain();
        apb_write(REG_STRIKE_LIMIT, 32'd2);
        send_tick(0, 0, 0);
        drain();

        write_settings(1'b1, 8'd255, TIMER_MAX, 24'd0, 24'd0);
        send_tick(1, 0, 0);
        send_tick(0, 0, 0);
        send_tick(1, 0, 0);
        send_tick(0, 1, 0);
        drain();

        for (int p = 0; p < PHASES; p++)
        begin
            if (p < 2)
            begin
                send_idle_pct = 31;
                recv_idle_pct = 75;
            end
            else if (p < 4)
            begin
                send_idle_pct = 75;
                recv_idle_pct = 31;
            end
            else
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            random_settings();
            random_ticks(PHASE_TICKS, p == 4);
            drain();
        end

        repeat (5) @(posedge clk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

### files.f
+incdir+src
src/msq_pkg.sv
src/msq_if.sv
src/motion_strike_qualifier.sv
sim/tb.sv
